// ----- rtl/core/pvbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pvbs_pkg
// Shared constants, word types and memory entry layouts of the phase-vocoder
// bin shift unit.
// ----------------------------------------------------------------------------
package pvbs_pkg;

    // Spectrum geometry
    localparam int BINS    = 512;
    localparam int OVERLAP = 4;
    localparam int BIN_W   = $clog2(BINS);

    // Field widths
    localparam int IDX_W    = 9;
    localparam int MAG_IN_W = 16;
    localparam int PH_W     = 16;
    localparam int MAG_W    = 20;
    localparam int RATIO_W  = 15;

    // Q3.12 shift ratio
    localparam int                 FRAC_W      = 12;
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(4096);

    // Derived arithmetic widths
    localparam int TGT_W  = IDX_W + RATIO_W - FRAC_W;
    localparam int ADV_W  = IDX_W + PH_W + 1;
    localparam int PROD_W = ADV_W + RATIO_W + 1;

    // Operation codes
    localparam logic OP_ANALYZE    = 1'b0;
    localparam logic OP_SYNTHESIZE = 1'b1;

    typedef struct packed {
        logic                op;
        logic [IDX_W-1:0]    bin_index;
        logic [MAG_IN_W-1:0] magnitude;
        logic [PH_W-1:0]     phase;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_bin;
        logic [MAG_W-1:0] syn_magnitude;
        logic [PH_W-1:0]  syn_phase;
    } result_t;

    // Per-bin phase memory entry
    typedef struct packed {
        logic [PH_W-1:0] running;
        logic [PH_W-1:0] previous;
    } phase_entry_t;

    // Per-target shifted spectrum entry
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [PH_W-1:0]  advance;
    } shift_entry_t;

    // Stage enables for the advance datapath
    typedef struct packed {
        logic calc_en;
        logic scale_en;
    } calc_ctl_t;

endpackage

// ----- rtl/core/pvbs_advance.sv -----
// ----------------------------------------------------------------------------
// pvbs_advance
// Two-stage datapath: target bin and true phase advance in the first stage,
// advance scaled by the shift ratio with round-half-up in the second.
// ----------------------------------------------------------------------------
module pvbs_advance
    import pvbs_pkg::*;
(
    input  logic               clk,
    input  calc_ctl_t          ctl,
    input  logic [IDX_W-1:0]   bin_index,
    input  logic [PH_W-1:0]    phase,
    input  logic [PH_W-1:0]    prev_phase,
    input  logic [RATIO_W-1:0] ratio,
    output logic [TGT_W-1:0]   target,
    output logic               target_ok,
    output logic [PH_W-1:0]    scaled_adv
);

    localparam int TP_W = IDX_W + RATIO_W;

    logic [TP_W-1:0]         tgt_prod;
    logic [TGT_W-1:0]        target_reg;
    logic [TGT_W-1:0]        target_next;
    logic [IDX_W+PH_W-1:0]   k_turns;
    logic signed [ADV_W-1:0] expected;
    logic [PH_W-1:0]         diff;
    logic signed [ADV_W-1:0] adv_reg;
    logic signed [ADV_W-1:0] adv_next;
    logic signed [PROD_W-1:0] scale_prod;
    logic signed [PROD_W-1:0] scale_sum;
    logic [PH_W-1:0]         scaled_reg;
    logic [PH_W-1:0]         scaled_next;

    // Map bin k to floor(k * ratio) in Q3.12
    assign tgt_prod    = TP_W'(bin_index) * TP_W'(ratio);
    assign target_next = tgt_prod[TP_W-1:FRAC_W];

    // Expected hop advance, wrapped deviation, true advance
    assign k_turns  = {bin_index, PH_W'(0)};
    assign expected = ADV_W'(k_turns / OVERLAP);
    assign diff     = phase - prev_phase - expected[PH_W-1:0];
    assign adv_next = expected + ADV_W'($signed(diff));

    // Scale the advance and round half up
    assign scale_prod  = adv_reg * $signed({1'b0, ratio});
    assign scale_sum   = scale_prod + PROD_W'(1 << (FRAC_W - 1));
    assign scaled_next = scale_sum[FRAC_W+PH_W-1:FRAC_W];

    // Hold stage results until the next enable
    always_ff @(posedge clk)
    begin
        if (ctl.calc_en)
        begin
            target_reg <= target_next;
            adv_reg    <= adv_next;
        end
        if (ctl.scale_en)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign target     = target_reg;
    assign target_ok  = {1'b0, target_reg} < (TGT_W + 1)'(BINS);
    assign scaled_adv = scaled_reg;

endmodule

// ----- rtl/core/phase_vocoder_bin_shift_unit.sv -----
// ----------------------------------------------------------------------------
// phase_vocoder_bin_shift_unit
// Phase-vocoder pitch shift core: analysis, bin remapping, phase accumulation.
// ----------------------------------------------------------------------------
// After reset the unit sweeps both bin memories to zero, one bin per cycle,
// over all BINS (512) bins with busy high; cfg_we is taken during that time.
// Each word then passes the calc, scale and write-back states: busy rises at
// the accepting edge and falls after the write-back. Every word does a
// read-modify-write of the per-bin phase memory, and of the shifted spectrum
// memory unless an analyze word's target bin is out of range, with the reads
// registered and two datapath stages in between. A synthesize word puts its
// result on the result port with done high for one cycle, after its
// write-back; there is no back-pressure, so the receiver must take it then.
// Analyze words return nothing. Write shift_ratio only while busy is low.
module phase_vocoder_bin_shift_unit
    import pvbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  item_t              item,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [RATIO_W-1:0] cfg_data,
    output logic               done,
    output result_t            result
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_SCALE,
        S_WB
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [BIN_W-1:0]   clr_cnt_reg;
    logic [BIN_W-1:0]   clr_cnt_next;
    item_t              item_reg;
    item_t              item_next;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;
    logic [RATIO_W-1:0] shift_ratio_reg;

    logic               accept;
    logic               in_range;
    calc_ctl_t          calc_ctl;
    logic [TGT_W-1:0]   target;
    logic               target_ok;
    logic [PH_W-1:0]    scaled_adv;

    // Memories
    phase_entry_t       phase_mem [BINS];
    shift_entry_t       shift_mem [BINS];
    phase_entry_t       pm_q;
    shift_entry_t       sm_q;
    logic               pm_re;
    logic [BIN_W-1:0]   pm_raddr;
    logic               pm_we;
    logic [BIN_W-1:0]   pm_waddr;
    phase_entry_t       pm_wdata;
    logic               sm_re;
    logic [BIN_W-1:0]   sm_raddr;
    logic               sm_we;
    logic [BIN_W-1:0]   sm_waddr;
    shift_entry_t       sm_wdata;
    logic [MAG_W:0]     mag_sum;
    logic [MAG_W-1:0]   mag_sat;
    logic [PH_W-1:0]    run_new;
    logic [BIN_W-1:0]   k_addr;

    assign accept   = start && !busy;
    assign busy     = state_reg != S_IDLE;
    assign in_range = {1'b0, item.bin_index} < (IDX_W + 1)'(BINS);
    assign k_addr   = item_reg.bin_index[BIN_W-1:0];

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_ratio_reg <= RATIO_RESET;
        end
        else if (cfg_we)
        begin
            shift_ratio_reg <= cfg_data;
        end
    end

    // Advance datapath
    assign calc_ctl.calc_en  = state_reg == S_CALC;
    assign calc_ctl.scale_en = state_reg == S_SCALE;

    pvbs_advance u_advance (
        .clk        (clk),
        .ctl        (calc_ctl),
        .bin_index  (item_reg.bin_index),
        .phase      (item_reg.phase),
        .prev_phase (pm_q.previous),
        .ratio      (shift_ratio_reg),
        .target     (target),
        .target_ok  (target_ok),
        .scaled_adv (scaled_adv)
    );

    // Write-back values
    assign mag_sum = {1'b0, sm_q.magnitude} + (MAG_W + 1)'(item_reg.magnitude);
    assign mag_sat = mag_sum[MAG_W] ? {MAG_W{1'b1}} : mag_sum[MAG_W-1:0];
    assign run_new = pm_q.running + sm_q.advance;

    // Memory port control
    always_comb
    begin
        pm_re    = accept && in_range;
        pm_raddr = item.bin_index[BIN_W-1:0];
        pm_we    = 1'b0;
        pm_waddr = k_addr;
        pm_wdata = pm_q;
        sm_re    = state_reg == S_SCALE;
        sm_raddr = (item_reg.op == OP_SYNTHESIZE) ? k_addr : target[BIN_W-1:0];
        sm_we    = 1'b0;
        sm_waddr = sm_raddr;
        sm_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_cnt_reg;
                pm_wdata = '0;
                sm_we    = 1'b1;
                sm_waddr = clr_cnt_reg;
            end
            S_WB:
            begin
                pm_we = 1'b1;
                if (item_reg.op == OP_SYNTHESIZE)
                begin
                    pm_wdata.running = run_new;
                    sm_we            = 1'b1;
                    sm_waddr         = k_addr;
                end
                else
                begin
                    pm_wdata.previous  = item_reg.phase;
                    sm_we              = target_ok;
                    sm_waddr           = target[BIN_W-1:0];
                    sm_wdata.magnitude = mag_sat;
                    sm_wdata.advance   = scaled_adv;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Phase memory
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            phase_mem[pm_waddr] <= pm_wdata;
        end
        if (pm_re)
        begin
            pm_q <= phase_mem[pm_raddr];
        end
    end

    // Shifted spectrum memory
    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            shift_mem[sm_waddr] <= sm_wdata;
        end
        if (sm_re)
        begin
            sm_q <= shift_mem[sm_raddr];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        item_next    = item_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + BIN_W'(1);
                if (clr_cnt_reg == BIN_W'(BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && in_range)
                begin
                    item_next  = item;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_IDLE;
                if (item_reg.op == OP_SYNTHESIZE)
                begin
                    done_next                 = 1'b1;
                    result_next.out_bin       = item_reg.bin_index;
                    result_next.syn_magnitude = sm_q.magnitude;
                    result_next.syn_phase     = run_new;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            item_reg    <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            item_reg    <= item_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result word only follows the write-back of a synthesize word
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_WB && item_reg.op == OP_SYNTHESIZE))
        else $error("result strobe without a synthesize write-back");

    // Result strobes never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // The clearing sweep ends after the last bin
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_cnt_reg == BIN_W'(BINS - 1)) |=> state_reg == S_IDLE)
        else $error("clearing sweep did not finish at the last bin");

    // The scaling stage always follows the calculation stage
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |=> (state_reg == S_SCALE))
        else $error("sequencer skipped the scaling stage");

endmodule
